[src/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the per-unit encoder shared by the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int RunBytes = 6;

    localparam logic [5:0]  SurrHighTag = 6'b110110;
    localparam logic [5:0]  SurrLowTag  = 6'b110111;
    localparam logic [20:0] SuppBase    = 21'h10000;
    localparam logic [7:0]  Lead4       = 8'hF0;
    localparam logic [7:0]  Lead3       = 8'hE0;
    localparam logic [7:0]  Lead2       = 8'hC0;
    localparam logic [7:0]  ContTag     = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       end_of_string;
    } out_item_t;

    // bytes caused by one item; count 0 with last set is the end marker
    typedef struct packed {
        logic [RunBytes-1:0][7:0] bytes;
        logic [2:0]               count;
        logic                     last;
    } run_t;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } enc_t;

    function automatic enc_t u16_encode(input logic [15:0] u);
        enc_t e;
        e = '0;
        if (u[15:7] == 9'd0) begin
            e.b[0] = u[7:0];
            e.n    = 2'd1;
        end
        else if (u[15:11] == 5'd0) begin
            e.b[0] = Lead2 | {3'b000, u[10:6]};
            e.b[1] = ContTag | {2'b00, u[5:0]};
            e.n    = 2'd2;
        end
        else begin
            e.b[0] = Lead3 | {4'h0, u[15:12]};
            e.b[1] = ContTag | {2'b00, u[11:6]};
            e.b[2] = ContTag | {2'b00, u[5:0]};
            e.n    = 2'd3;
        end
        return e;
    endfunction

endpackage

[src/utf16_to_utf8_encoder.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 to UTF-8 transcoder, one code unit in, one UTF-8 byte out per item.
//
// Input channel in_valid/in_ready/in_item carries a code unit and a flag for
// the string's last unit. Output channel out_valid/out_ready/out_item carries
// one byte with its run and string end marks; a string that ends without a
// byte gives one item with byte_valid low.
// The front classifies a unit in the cycle it is taken and writes its run
// (0 to 6 bytes) into a two-entry queue; the back drains the queue through
// the output register at one byte per cycle while the receiver takes them.
// The first byte of a run passes through the queue entry and then the output
// register after the unit is taken.
// The front can take new units while the back still serialises earlier runs;
// the byte-wide output register sets the pace of the bytes.
// A receiver stall holds the output register; the queue keeps taking units
// until both entries are full, then in_ready drops.
// Reset clears the surrogate and string state, the queue and the output.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic push_valid;
    logic push_ready;
    run_t push_run;
    logic head_valid;
    run_t head_run;
    logic pop;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run)
    );

    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run),
        .head_valid (head_valid),
        .pop        (pop),
        .head_run   (head_run)
    );

    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

[src/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks surrogate and string state, and builds the byte
// run of each item for the queue.
// ----------------------------------------------------------------------------
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     push_valid,
    input  logic     push_ready,
    output run_t     push_run
);

    logic [9:0] held_bits_reg, held_bits_next;
    logic       held_reg, held_next;
    logic       stopped_reg, stopped_next;
    logic       accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb
    begin
        logic [15:0] cu;
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        enc_t        eh;
        enc_t        eu;
        run_t        r;

        cu      = in_item.code_unit;
        is_high = (cu[15:10] == SurrHighTag);
        is_low  = (cu[15:10] == SurrLowTag);
        cp      = SuppBase + {1'b0, held_bits_reg, cu[9:0]};
        eh      = u16_encode({SurrHighTag, held_bits_reg});
        eu      = u16_encode(cu);
        r       = '0;

        held_bits_next = held_bits_reg;
        held_next      = held_reg;
        stopped_next   = stopped_reg;

        if (!stopped_reg) begin
            if (held_reg && is_low) begin
                r.bytes[0]     = Lead4 | {5'd0, cp[20:18]};
                r.bytes[1]     = ContTag | {2'b00, cp[17:12]};
                r.bytes[2]     = ContTag | {2'b00, cp[11:6]};
                r.bytes[3]     = ContTag | {2'b00, cp[5:0]};
                r.count        = 3'd4;
                held_next      = 1'b0;
                held_bits_next = '0;
            end
            else begin
                if (held_reg) begin
                    r.bytes[0]     = eh.b[0];
                    r.bytes[1]     = eh.b[1];
                    r.bytes[2]     = eh.b[2];
                    r.count        = 3'd3;
                    held_next      = 1'b0;
                    held_bits_next = '0;
                end
                if (cu == 16'd0) begin
                    stopped_next = 1'b1;
                end
                else if (is_high && !in_item.last_unit) begin
                    held_bits_next = cu[9:0];
                    held_next      = 1'b1;
                end
                else begin
                    if (held_reg) begin
                        r.bytes[3] = eu.b[0];
                        r.bytes[4] = eu.b[1];
                        r.bytes[5] = eu.b[2];
                    end
                    else begin
                        r.bytes[0] = eu.b[0];
                        r.bytes[1] = eu.b[1];
                        r.bytes[2] = eu.b[2];
                    end
                    r.count = r.count + {1'b0, eu.n};
                end
            end
        end

        r.last = in_item.last_unit;
        if (in_item.last_unit) begin
            held_next      = 1'b0;
            held_bits_next = '0;
            stopped_next   = 1'b0;
        end

        push_run   = r;
        push_valid = in_valid && ((r.count != 3'd0) || in_item.last_unit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_bits_reg <= '0;
            held_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else if (accept) begin
            held_bits_reg <= held_bits_next;
            held_reg      <= held_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

[src/u16u8_queue.sv]
// ----------------------------------------------------------------------------
// u16u8_queue
// Two-entry queue of byte runs between the front and the serialiser.
// ----------------------------------------------------------------------------
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  run_t push_run,
    output logic head_valid,
    input  logic pop,
    output run_t head_run
);

    run_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_run   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[src/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Serialises the head run one byte per cycle into the output register while the receiver takes them.
// ----------------------------------------------------------------------------
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  run_t      head_run,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!out_valid_reg || out_ready);
    assign final_byte = (head_run.count == 3'd0) || (idx_reg == head_run.count - 3'd1);
    assign pop        = load && final_byte;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    always_comb
    begin
        out_next.out_byte      = (head_run.count == 3'd0) ? 8'd0 : head_run.bytes[idx_reg];
        out_next.byte_valid    = (head_run.count != 3'd0);
        out_next.last_of_run   = final_byte;
        out_next.end_of_string = final_byte && head_run.last;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = final_byte ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[tb/utf16_to_utf8_encoder_chk.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_chk
// Watches both channels of the UTF-16 to UTF-8 transcoder. Every unit taken
// is run through a local model of the surrogate and string state. The UTF-8
// bytes it should cause are queued, and each byte given out is checked field
// by field against the oldest one waiting. The error count, the number of
// bytes still due and the number checked go back to the testbench top.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_chk
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        errors,
    output int        outstanding,
    output int        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [9:0] held_bits;
    logic       held;
    logic       stopped;
    logic [7:0] run_bytes[$];
    out_item_t  pending_bytes[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic put_utf8(input logic [15:0] u);
        if (u < 16'h0080)
        begin
            run_bytes.push_back(u[7:0]);
        end
        else if (u < 16'h0800)
        begin
            run_bytes.push_back(8'hC0 | {3'b000, u[10:6]});
            run_bytes.push_back(8'h80 | {2'b00, u[5:0]});
        end
        else
        begin
            run_bytes.push_back(8'hE0 | {4'h0, u[15:12]});
            run_bytes.push_back(8'h80 | {2'b00, u[11:6]});
            run_bytes.push_back(8'h80 | {2'b00, u[5:0]});
        end
    endtask

    task automatic drain_held();
        if (held)
        begin
            put_utf8({6'b110110, held_bits});
            held      = 1'b0;
            held_bits = '0;
        end
    endtask

    task automatic transcode_unit(input in_item_t it);
        logic [15:0] cu;
        logic        fin;
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        out_item_t   r;
        int          n;
        int          k;
        cu      = it.code_unit;
        fin     = it.last_unit;
        is_high = (cu >= 16'hD800) && (cu <= 16'hDBFF);
        is_low  = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
        run_bytes.delete();
        if (!stopped)
        begin
            if (held && is_low)
            begin
                cp = 21'h10000 + {1'b0, held_bits, cu[9:0]};
                run_bytes.push_back(8'hF0 | {5'b00000, cp[20:18]});
                run_bytes.push_back(8'h80 | {2'b00, cp[17:12]});
                run_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
                run_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
                held      = 1'b0;
                held_bits = '0;
            end
            else
            begin
                drain_held();
                if (cu == 16'h0000)
                begin
                    stopped = 1'b1;
                end
                else if (is_high && !fin)
                begin
                    held_bits = cu[9:0];
                    held      = 1'b1;
                end
                else
                begin
                    put_utf8(cu);
                end
            end
        end
        if (fin)
        begin
            drain_held();
        end
        n = run_bytes.size();
        for (k = 0; k < n; k++)
        begin
            r.out_byte      = run_bytes[k];
            r.byte_valid    = 1'b1;
            r.last_of_run   = (k == n - 1);
            r.end_of_string = fin && (k == n - 1);
            pending_bytes.push_back(r);
        end
        if (fin)
        begin
            if (n == 0)
            begin
                r.out_byte      = 8'h00;
                r.byte_valid    = 1'b0;
                r.last_of_run   = 1'b1;
                r.end_of_string = 1'b1;
                pending_bytes.push_back(r);
            end
            held      = 1'b0;
            held_bits = '0;
            stopped   = 1'b0;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected item byte=%02h valid=%0b run=%0b end=%0b",
                got.out_byte, got.byte_valid, got.last_of_run, got.end_of_string));
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte,
                    want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %0b, want %0b", got.byte_valid,
                    want.byte_valid));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, want %0b", got.last_of_run,
                    want.last_of_run));
            if (got.end_of_string !== want.end_of_string)
                report_mismatch($sformatf("end_of_string %0b, want %0b", got.end_of_string,
                    want.end_of_string));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held      = 1'b0;
            held_bits = '0;
            stopped   = 1'b0;
            pending_bytes.delete();
            errors      = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                transcode_unit(in_item);
            if (out_valid && out_ready)
            begin
                check_result(out_item);
                checked++;
            end
            outstanding = pending_bytes.size();
        end
    end

endmodule

[tb/utf16_to_utf8_encoder_tb.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_tb
// Drives strings of UTF-16 code units into the transcoder: a directed set of
// boundary units and surrogate cases, a flood against a long receiver
// hold-off, then random strings, mostly well formed with some noise. The
// sender runs in bursts and the receiver stalls on its own pattern; the
// checker beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    typedef enum int {
        UnitAscii,
        UnitTwo,
        UnitThree,
        UnitHigh,
        UnitLow,
        UnitZero,
        UnitAny
    } unit_kind_t;

    localparam int CycleLimit    = 200000;
    localparam int HoldOffCycles = 400;
    localparam int FloodUnits    = 40;
    localparam int RandomUnits   = 395;
    localparam int TailCycles    = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    in_item_t  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_item;

    int   errors;
    int   outstanding;
    int   checked;
    int   cycles       = 0;
    int   units_sent   = 0;
    int   live_units   = 0;
    int   strings_sent = 0;
    int   pairs_sent   = 0;
    int   burst_left   = 0;
    logic str_stopped  = 1'b0;
    logic flood        = 1'b0;
    logic hold_done    = 1'b0;

    in_item_t directed_seq [0:24] = '{
        '{16'h0041, 1'b0}, '{16'h007F, 1'b0}, '{16'h0080, 1'b0}, '{16'h07FF, 1'b0},
        '{16'h0800, 1'b0}, '{16'hFFFF, 1'b0}, '{16'hD800, 1'b0}, '{16'hDC00, 1'b0},
        '{16'hDBFF, 1'b0}, '{16'hDFFF, 1'b0}, '{16'hD834, 1'b0}, '{16'h0041, 1'b0},
        '{16'hDC12, 1'b0}, '{16'h0001, 1'b1},
        '{16'hD83D, 1'b1},
        '{16'h0042, 1'b0}, '{16'h0000, 1'b0}, '{16'h0043, 1'b0}, '{16'h0800, 1'b1},
        '{16'h0000, 1'b1},
        '{16'hD801, 1'b0}, '{16'h0000, 1'b0}, '{16'h0044, 1'b1},
        '{16'hD900, 1'b0}, '{16'hDA00, 1'b1}
    };

    utf16_to_utf8_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    utf16_to_utf8_encoder_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("utf16_to_utf8_encoder_tb failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_unit(input unit_kind_t kind);
        case (kind)
            UnitAscii: return 16'($urandom_range(1, 16'h007F));
            UnitTwo:   return 16'($urandom_range(16'h0080, 16'h07FF));
            UnitThree:
                if ($urandom_range(0, 1) == 0)
                    return 16'($urandom_range(16'h0800, 16'hD7FF));
                else
                    return 16'($urandom_range(16'hE000, 16'hFFFF));
            UnitHigh:  return 16'hD800 | 16'($urandom_range(0, 10'h3FF));
            UnitLow:   return 16'hDC00 | 16'($urandom_range(0, 10'h3FF));
            UnitZero:  return 16'h0000;
            default:   return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // bursts of random length; now and then a long stretch with no gaps
    task automatic pace();
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(60, 120);
            else
                burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_unit(input logic [15:0] cu, input logic fin);
        in_item  <= '{code_unit: cu, last_unit: fin};
        in_valid <= 1'b1;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        units_sent++;
        if (!str_stopped)
            live_units++;
        if (cu == 16'h0000)
            str_stopped = 1'b1;
        if (fin)
        begin
            str_stopped = 1'b0;
            strings_sent++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_string();
        int         shape;
        int         nchars;
        int         i;
        logic       terminate;
        logic       fin;
        unit_kind_t kind;
        shape = $urandom_range(0, 9);
        if (shape < 7)
        begin
            nchars    = $urandom_range(1, 10);
            terminate = ($urandom_range(0, 5) == 0);
            for (i = 0; i < nchars; i++)
            begin
                fin = (i == nchars - 1) && !terminate;
                pace();
                case ($urandom_range(0, 4))
                    0, 4: send_unit(pick_unit(UnitAscii), fin);
                    1:    send_unit(pick_unit(UnitTwo), fin);
                    2:    send_unit(pick_unit(UnitThree), fin);
                    default:
                    begin
                        send_unit(pick_unit(UnitHigh), 1'b0);
                        pace();
                        send_unit(pick_unit(UnitLow), fin);
                        pairs_sent++;
                    end
                endcase
            end
            if (terminate)
            begin
                pace();
                send_unit(16'h0000, 1'b0);
                pace();
                send_unit(pick_unit(UnitAny), 1'b1);
            end
        end
        else
        begin
            nchars = $urandom_range(1, 8);
            for (i = 0; i < nchars; i++)
            begin
                kind = unit_kind_t'($urandom_range(UnitAscii, UnitAny));
                pace();
                send_unit(pick_unit(kind), i == nchars - 1);
            end
        end
    endtask

    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (flood && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 4) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 25; i++)
        begin
            pace();
            send_unit(directed_seq[i].code_unit, directed_seq[i].last_unit);
        end
        wait_drained();

        // receiver holds off while the sender keeps pushing
        flood = 1'b1;
        for (i = 0; i < FloodUnits; i++)
            send_unit(pick_unit(UnitThree), i == FloodUnits - 1);
        wait_drained();

        live_units = 0;
        while (live_units < RandomUnits)
            send_string();
        wait_drained();
        repeat (TailCycles) @(posedge clk);

        $display("%0d code units in %0d strings, %0d surrogate pairs, %0d output items checked",
            units_sent, strings_sent, pairs_sent, checked);
        $display("receiver held off %0d cycles under load; sender drained between phases",
            HoldOffCycles);
        if (errors == 0)
            $display("utf16_to_utf8_encoder_tb passed");
        else
            $display("utf16_to_utf8_encoder_tb failed");
        $finish;
    end

endmodule

[filelist.f]
src/u16u8_pkg.sv
src/u16u8_front.sv
src/u16u8_queue.sv
src/u16u8_back.sv
src/utf16_to_utf8_encoder.sv
tb/utf16_to_utf8_encoder_chk.sv
tb/utf16_to_utf8_encoder_tb.sv
